// ===== rtl/core/pswu_pkg.sv =====
// ----------------------------------------------------------------------------
// pswu_pkg
// Shared types, codes and helpers of the particle swarm update unit.
// ----------------------------------------------------------------------------
package pswu_pkg;

  localparam int MAX_PARTICLES_DEF = 128;
  localparam int MAX_DIMS_DEF      = 16;

  // command fields are sized for the largest legal parameter values
  localparam int CLR_W   = 20;
  localparam int CIDX_W  = 8;
  localparam int MSTEP_W = 4;
  localparam int ACC_W   = 40;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_BOUNDS = 3'd1;
  localparam logic [2:0] OP_FIT    = 3'd2;
  localparam logic [2:0] OP_MOVE   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] CFG_INERTIA   = 2'd0;
  localparam logic [1:0] CFG_COGNITIVE = 2'd1;
  localparam logic [1:0] CFG_SOCIAL    = 2'd2;
  localparam logic [1:0] CFG_DIMS      = 2'd3;

  // move sequence steps
  localparam logic [MSTEP_W-1:0] MV_VEL   = 4'd0;
  localparam logic [MSTEP_W-1:0] MV_COG   = 4'd1;
  localparam logic [MSTEP_W-1:0] MV_SOC   = 4'd2;
  localparam logic [MSTEP_W-1:0] MV_PB    = 4'd3;
  localparam logic [MSTEP_W-1:0] MV_GB    = 4'd4;
  localparam logic [MSTEP_W-1:0] MV_ACC   = 4'd5;
  localparam logic [MSTEP_W-1:0] MV_VSAT  = 4'd6;
  localparam logic [MSTEP_W-1:0] MV_XSAT  = 4'd7;
  localparam logic [MSTEP_W-1:0] MV_CLAMP = 4'd8;

  localparam logic signed [31:0] FIT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               load;
    logic               dec;
    logic               fit_eval;
    logic               copy_rd;
    logic [CIDX_W-1:0]  copy_idx;
    logic               mv_en;
    logic [MSTEP_W-1:0] mv_step;
    logic               clr_en;
    logic [CLR_W-1:0]   clr_idx;
  } pswu_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ok;
    logic       better;
    logic       copy_last;
    logic       clr_last;
  } pswu_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff})) r = 32'sh7fff_ffff;
    else if (x < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000})) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/pswu_ram.sv =====
// ----------------------------------------------------------------------------
// pswu_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pswu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/pswu_datapath.sv =====
// ----------------------------------------------------------------------------
// pswu_datapath
// Swarm state stores, config registers and the shared move multiplier.
// ----------------------------------------------------------------------------
module pswu_datapath import pswu_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int MAX_DIMS      = MAX_DIMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pswu_cmd_t           cmd_i,
  output pswu_status_t        status_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [2:0]          operation_i,
  input  logic [6:0]          particle_i,
  input  logic [3:0]          dimension_i,
  input  logic signed [31:0]  value_i,
  input  logic signed [31:0]  upper_value_i,
  input  logic [15:0]         random_personal_i,
  input  logic [15:0]         random_global_i,
  output logic signed [31:0]  result_value_o,
  output logic                personal_improved_o,
  output logic                global_improved_o,
  output logic                result_status_o
);

  localparam int DEPTH = MAX_PARTICLES * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_PARTICLES);
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NDW   = $clog2(MAX_DIMS + 1);

  // config
  logic signed [15:0] w_q, cg_q, sg_q;
  logic [4:0]         dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= 16'sd4096;
      cg_q <= 16'sd8192;
      sg_q <= 16'sd8192;
      dc_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INERTIA:   w_q  <= cfg_data_i;
        CFG_COGNITIVE: cg_q <= cfg_data_i;
        CFG_SOCIAL:    sg_q <= cfg_data_i;
        CFG_DIMS:      dc_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // item
  logic [2:0]         op_q;
  logic [6:0]         p_q;
  logic [3:0]         d_q;
  logic signed [31:0] val_q, upv_q;
  logic [15:0]        r1_q, r2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      p_q   <= particle_i;
      d_q   <= dimension_i;
      val_q <= value_i;
      upv_q <= upper_value_i;
      r1_q  <= random_personal_i;
      r2_q  <= random_global_i;
    end
  end

  logic [NDW-1:0] nd;
  logic           p_ok, d_ok, ok;
  logic [AW-1:0]  base, k;
  logic [PW-1:0]  pidx;
  logic [DW-1:0]  didx;

  always_comb begin
    if (dc_q == 5'd0) nd = NDW'(1);
    else if (32'(dc_q) > MAX_DIMS) nd = NDW'(MAX_DIMS);
    else nd = NDW'(dc_q);
    p_ok = 32'(p_q) < MAX_PARTICLES;
    d_ok = 32'(d_q) < 32'(nd);
    unique case (op_q) inside
      OP_LOAD, OP_MOVE:   ok = p_ok && d_ok;
      OP_BOUNDS, OP_READ: ok = d_ok;
      OP_FIT:             ok = p_ok;
      default:            ok = 1'b0;
    endcase
    base = AW'(32'(p_q) * MAX_DIMS);
    k    = base + AW'(d_q);
    pidx = PW'(p_q);
    didx = DW'(d_q);
  end

  // register-held small stores
  logic signed [31:0] gb_q [MAX_DIMS];
  logic signed [31:0] lb_q [MAX_DIMS];
  logic signed [31:0] ub_q [MAX_DIMS];
  logic signed [31:0] gbf_q;

  // memories
  logic          pos_we, vel_we, pb_we, pbf_we;
  logic [AW-1:0] pos_wa, pos_ra, vel_wa, pb_wa;
  logic [PW-1:0] pbf_wa;
  logic [31:0]   pos_wd, vel_wd, pb_wd, pbf_wd;
  logic [31:0]   pos_rd, vel_rd, pb_rd, pbf_rd;

  logic               cp_pend_q;
  logic [DW-1:0]      cp_idx_q;
  logic               gimp_q, pimp_q, st_q;
  logic signed [31:0] res_q;
  logic signed [31:0] v_q, x_q, nx_q;
  logic               mv_wr;
  logic signed [31:0] nx_cl;

  assign mv_wr = cmd_i.mv_en && (cmd_i.mv_step == MV_CLAMP);

  always_comb begin
    if (nx_q > ub_q[didx]) nx_cl = ub_q[didx];
    else if (nx_q < lb_q[didx]) nx_cl = lb_q[didx];
    else nx_cl = nx_q;
  end

  always_comb begin
    pos_we = (cmd_i.dec && ok && op_q == OP_LOAD) || mv_wr;
    pos_wa = k;
    pos_wd = mv_wr ? nx_cl : val_q;
    pos_ra = cmd_i.copy_rd ? base + AW'(cmd_i.copy_idx) : k;

    vel_we = cmd_i.clr_en || (cmd_i.dec && ok && op_q == OP_LOAD) || mv_wr;
    vel_wa = cmd_i.clr_en ? AW'(cmd_i.clr_idx) : k;
    vel_wd = mv_wr ? v_q : 32'd0;

    pb_we  = cmd_i.clr_en || (cmd_i.dec && ok && op_q == OP_LOAD) || cp_pend_q;
    pb_wa  = cmd_i.clr_en ? AW'(cmd_i.clr_idx) : (cp_pend_q ? base + AW'(cp_idx_q) : k);
    pb_wd  = cp_pend_q ? pos_rd : 32'd0;

    pbf_we = (cmd_i.clr_en && 32'(cmd_i.clr_idx) < MAX_PARTICLES) ||
             (cmd_i.fit_eval && status_o.better);
    pbf_wa = cmd_i.clr_en ? PW'(cmd_i.clr_idx) : pidx;
    pbf_wd = cmd_i.clr_en ? FIT_MIN : val_q;
  end

  pswu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(pos_ra), .rdata_o(pos_rd));
  pswu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vel (
    .clk_i, .we_i(vel_we), .waddr_i(vel_wa), .wdata_i(vel_wd),
    .raddr_i(k), .rdata_o(vel_rd));
  pswu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pb (
    .clk_i, .we_i(pb_we), .waddr_i(pb_wa), .wdata_i(pb_wd),
    .raddr_i(k), .rdata_o(pb_rd));
  pswu_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pbf (
    .clk_i, .we_i(pbf_we), .waddr_i(pbf_wa), .wdata_i(pbf_wd),
    .raddr_i(pidx), .rdata_o(pbf_rd));

  // status
  always_comb begin
    status_o.op        = op_q;
    status_o.ok        = ok;
    status_o.better    = val_q > $signed(pbf_rd);
    status_o.copy_last = 32'(cmd_i.copy_idx) == 32'(nd) - 1;
    status_o.clr_last  = 32'(cmd_i.clr_idx) == DEPTH - 1;
  end

  // shared multiplier for the move sequence
  logic signed [17:0]      opa;
  logic signed [33:0]      opb;
  logic signed [51:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [17:0]      g1_q, g2_q;
  logic signed [32:0]      d1_q, d2_q;
  logic signed [ACC_W-1:0] prod_s12;
  logic signed [51:0]      prod_s16;
  logic signed [ACC_W-1:0] xv;

  assign prod_s12 = ACC_W'(prod_q >>> 12);
  assign prod_s16 = prod_q >>> 16;
  assign xv       = ACC_W'(x_q) + ACC_W'(v_q);

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.mv_step)
      MV_VEL: begin
        opa = 18'(w_q);
        opb = 34'($signed(vel_rd));
      end
      MV_COG: begin
        opa = 18'(cg_q);
        opb = $signed({18'd0, r1_q});
      end
      MV_SOC: begin
        opa = 18'(sg_q);
        opb = $signed({18'd0, r2_q});
      end
      MV_PB: begin
        opa = g1_q;
        opb = 34'(d1_q);
      end
      MV_GB: begin
        opa = g2_q;
        opb = 34'(d2_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_en) begin
      prod_q <= opa * opb;
      case (cmd_i.mv_step)
        MV_VEL: begin
          x_q  <= $signed(pos_rd);
          d1_q <= 33'($signed(pb_rd)) - 33'($signed(pos_rd));
          d2_q <= 33'(gb_q[didx]) - 33'($signed(pos_rd));
        end
        MV_COG:  acc_q <= prod_s12;
        MV_SOC:  g1_q  <= 18'(prod_s16);
        MV_PB:   g2_q  <= 18'(prod_s16);
        MV_GB:   acc_q <= acc_q + prod_s12;
        MV_ACC:  acc_q <= acc_q + prod_s12;
        MV_VSAT: v_q   <= sat32(acc_q);
        MV_XSAT: nx_q  <= sat32(xv);
        default: ;
      endcase
    end
  end

  // bounds and global best
  always_ff @(posedge clk_i) begin
    if (cmd_i.dec && ok && op_q == OP_BOUNDS) begin
      lb_q[didx] <= val_q;
      ub_q[didx] <= upv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) gb_q[i] <= '0;
      gbf_q     <= FIT_MIN;
      cp_pend_q <= 1'b0;
    end else begin
      cp_pend_q <= cmd_i.copy_rd;
      if (cmd_i.fit_eval && status_o.better && val_q > gbf_q) gbf_q <= val_q;
      if (cp_pend_q && gimp_q) gb_q[cp_idx_q] <= $signed(pos_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    cp_idx_q <= DW'(cmd_i.copy_idx);
  end

  // result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q  <= '0;
      pimp_q <= 1'b0;
      gimp_q <= 1'b0;
      st_q   <= 1'b0;
    end else if (cmd_i.dec) begin
      if (!ok) st_q <= 1'b1;
      else if (op_q == OP_LOAD || op_q == OP_BOUNDS) res_q <= val_q;
      else if (op_q == OP_READ) res_q <= gb_q[didx];
    end else if (cmd_i.fit_eval) begin
      pimp_q <= status_o.better;
      gimp_q <= status_o.better && val_q > gbf_q;
      res_q  <= (status_o.better && val_q > gbf_q) ? val_q : gbf_q;
    end else if (mv_wr) begin
      res_q <= nx_cl;
    end
  end

  assign result_value_o      = res_q;
  assign personal_improved_o = pimp_q;
  assign global_improved_o   = gimp_q;
  assign result_status_o     = st_q;

endmodule

// ===== rtl/core/pswu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pswu_ctrl
// Sequencer: clearing pass, decode, fitness copy loop and move steps.
// ----------------------------------------------------------------------------
module pswu_ctrl import pswu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  output logic         result_valid_o,
  input  pswu_status_t status_i,
  output pswu_cmd_t    cmd_o
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_FCMP  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_MOVE  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CLR_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.clr_idx  = cnt_q;
    cmd_o.copy_idx = cnt_q[CIDX_W-1:0];
    cmd_o.mv_step  = cnt_q[MSTEP_W-1:0];
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        cnt_d     = '0;
        if (!status_i.ok) state_d = S_OUT;
        else if (status_i.op == OP_FIT) state_d = S_FCMP;
        else if (status_i.op == OP_MOVE) state_d = S_MOVE;
        else state_d = S_OUT;
      end
      S_FCMP: begin
        cmd_o.fit_eval = 1'b1;
        state_d = status_i.better ? S_COPY : S_OUT;
      end
      S_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (status_i.copy_last) state_d = S_DRAIN;
        else cnt_d = cnt_q + 1'b1;
      end
      S_DRAIN: state_d = S_OUT;
      S_MOVE: begin
        cmd_o.mv_en = 1'b1;
        if (cnt_q[MSTEP_W-1:0] == MV_CLAMP) state_d = S_OUT;
        else cnt_d = cnt_q + 1'b1;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = state_q == S_OUT;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than a cycle");
  a_dec_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEC |-> $past(state_q) == S_IDLE) else $error("decode without accept");
  a_copy_from_better: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_COPY) |-> $past(state_q) == S_FCMP && $past(status_i.better))
    else $error("copy loop without improvement");

endmodule

// ===== rtl/core/particle_swarm_update_unit.sv =====
// ----------------------------------------------------------------------------
// particle_swarm_update_unit
// Global-best particle swarm engine, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   start & !busy          operation_i .. random_global_i
//  result    result_valid_o strobe  result_value_o, flags, status_o
//  config    cfg_we_i               cfg_idx_i, cfg_data_i
//
//  load, bounds, read and rejected beats pass through decode to the strobe.
//  report adds a fitness compare and, when the personal best improves, a
//  copy loop (one position RAM read per coordinate) and a drain state. move
//  steps the single shared multiplier through five products, then clamps.
//  after reset busy stays high for a clearing pass over MAX_PARTICLES*MAX_DIMS
//  entries; config writes are taken during it. the receiver cannot stall.
// ----------------------------------------------------------------------------
module particle_swarm_update_unit import pswu_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int MAX_DIMS      = MAX_DIMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [2:0]         operation_i,
  input  logic [6:0]         particle_i,
  input  logic [3:0]         dimension_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] upper_value_i,
  input  logic [15:0]        random_personal_i,
  input  logic [15:0]        random_global_i,
  output logic               result_valid_o,
  output logic signed [31:0] result_value_o,
  output logic               personal_improved_o,
  output logic               global_improved_o,
  output logic               status_o
);

  pswu_cmd_t    cmd;
  pswu_status_t stat;

  pswu_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .result_valid_o,
    .status_i(stat), .cmd_o(cmd));

  pswu_datapath #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_DIMS(MAX_DIMS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .operation_i, .particle_i, .dimension_i, .value_i, .upper_value_i,
    .random_personal_i, .random_global_i,
    .result_value_o, .personal_improved_o, .global_improved_o,
    .result_status_o(status_o));

endmodule
